// ----- hdl/i2cts_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cts_pkg
// Shared types, codes and field layouts for the I2C target byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cts_pkg;

  localparam int BUF_DEPTH = 16;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);
  localparam int RI_W      = 5;
  localparam int CFG_W     = 8;

  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 32;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_OVF   = 2'd1,
    REQ_LOAD  = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CM_NONE  = 2'd0,
    CM_ONE   = 2'd1,
    CM_EIGHT = 2'd2,
    CM_START = 2'd3
  } count_t;

  typedef enum logic [0:0] {
    CFG_OWN_ADDRESS = 1'b0,
    CFG_READ_LENGTH = 1'b1
  } cfg_idx_t;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_ADDR     = 7'b0000010,
    PH_WRITE    = 7'b0000100,
    PH_READ     = 7'b0001000,
    PH_ACKSEND  = 7'b0010000,
    PH_PREPACK  = 7'b0100000,
    PH_AWAITACK = 7'b1000000
  } phase_t;

  localparam logic [2:0] PC_IDLE     = 3'd0;
  localparam logic [2:0] PC_ADDR     = 3'd1;
  localparam logic [2:0] PC_WRITE    = 3'd2;
  localparam logic [2:0] PC_READ     = 3'd3;
  localparam logic [2:0] PC_ACKSEND  = 3'd4;
  localparam logic [2:0] PC_PREPACK  = 3'd5;
  localparam logic [2:0] PC_AWAITACK = 3'd6;

  typedef struct packed {
    logic [7:0]        buf_data;
    logic [BUF_AW-1:0] buf_addr;
    logic [7:0]        shift_in;
    req_t              req_type;
  } item_t;

  typedef struct packed {
    logic       command_valid;
    logic [7:0] command_byte;
    logic       ovf_enable;
    count_t     count_mode;
    logic       sda_latch;
    logic       sda_drive;
    logic [7:0] shift_out;
    logic       load_shift;
    logic [2:0] phase_code;
  } res_t;

  function automatic logic [2:0] phase_code_f(phase_t ph);
    logic [2:0] c;
    c = PC_IDLE;
    unique case (ph)
      PH_IDLE:     c = PC_IDLE;
      PH_ADDR:     c = PC_ADDR;
      PH_WRITE:    c = PC_WRITE;
      PH_READ:     c = PC_READ;
      PH_ACKSEND:  c = PC_ACKSEND;
      PH_PREPACK:  c = PC_PREPACK;
      PH_AWAITACK: c = PC_AWAITACK;
      default:     c = PC_IDLE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/i2c_target_byte_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// i2c_target_byte_sequencer_core
// I2C target byte sequencer above a shift-register unit: address match,
// command capture, buffered read streaming.
//
//   channel  dir  width  fields (lsb first)
//   s_tdata  in   24     shift_in[7:0] buf_addr[11:8] buf_data[19:12]
//   s_tuser  in   2      req_type[1:0]
//   m_tdata  out  32     phase_code load_shift shift_out sda_drive sda_latch
//                        count_mode ovf_enable command_byte command_valid
//   cfg      in   8      cfg_index 0 own_address, 1 read_length
//
// one request per clock unless m_tready low stalls the result; input register, then result register
// the state update is a single combinational pass between the two registers
// m_tready low holds the result; the input register still takes one request
// reset is synchronous; the read buffer holds no reset value
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_target_byte_sequencer_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // shift_in[7:0], buf_addr[11:8], buf_data[19:12], zero pad
  input  wire logic [i2cts_pkg::S_TDATA_W-1:0] s_tdata,
  // req_type[1:0]
  input  wire logic [i2cts_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // phase_code[2:0], load_shift[3], shift_out[11:4], sda_drive[12],
  // sda_latch[13], count_mode[15:14], ovf_enable[16], command_byte[24:17],
  // command_valid[25], zero pad
  output logic [i2cts_pkg::M_TDATA_W-1:0]      m_tdata,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [i2cts_pkg::CFG_W-1:0]     cfg_wdata
);
  import i2cts_pkg::*;

  logic  in_valid;
  item_t in_item;
  logic  out_valid;
  res_t  out_res;
  res_t  step_res;
  logic  step;

  assign step     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.req_type <= req_t'(s_tuser[1:0]);
      in_item.shift_in <= s_tdata[7:0];
      in_item.buf_addr <= s_tdata[8 +: BUF_AW];
      in_item.buf_data <= s_tdata[19:12];
    end
  end

  i2cts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_idx_t'(cfg_index)),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (in_item),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'(out_res);

endmodule

`default_nettype wire

// ----- hdl/i2cts_ctrl.sv -----
// ----------------------------------------------------------------------------
// i2cts_ctrl
// Sequencer state, read buffer and config registers; one request per step.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cts_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire i2cts_pkg::cfg_idx_t     cfg_index,
  input  wire logic [i2cts_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                    step,
  input  wire i2cts_pkg::item_t        item,
  output i2cts_pkg::res_t              res
);
  import i2cts_pkg::*;

  logic [7:0]      own_address;
  logic [RI_W-1:0] read_length;

  phase_t          phase, phase_next;
  phase_t          phase_after_ack, phase_after_ack_next;
  count_t          count_after_ack, count_after_ack_next;
  logic [RI_W-1:0] read_index, read_index_next;
  logic [7:0]      command_reg, command_reg_next;
  logic            ovf_irq_on, ovf_irq_on_next;
  logic            latch_level, latch_level_next;
  logic            sda_dir, sda_dir_next;

  logic [7:0]      rbuf [BUF_DEPTH];

  logic            rd_hit;
  logic            rd_in;
  logic [7:0]      rd_byte;
  logic            o_load;
  logic [7:0]      o_shift;
  count_t          o_count;
  logic            o_cmdvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
      read_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_ADDRESS: own_address <= cfg_wdata[7:0];
        CFG_READ_LENGTH: read_length <= cfg_wdata[RI_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step && item.req_type == REQ_LOAD) begin
      rbuf[item.buf_addr] <= item.buf_data;
    end
  end

  assign rd_hit  = read_index < read_length;
  assign rd_in   = read_index < RI_W'(BUF_DEPTH);
  assign rd_byte = (rd_hit && rd_in) ? rbuf[read_index[BUF_AW-1:0]] : 8'h00;

  always_comb begin
    phase_next           = phase;
    phase_after_ack_next = phase_after_ack;
    count_after_ack_next = count_after_ack;
    read_index_next      = read_index;
    command_reg_next     = command_reg;
    ovf_irq_on_next      = ovf_irq_on;
    latch_level_next     = latch_level;
    sda_dir_next         = sda_dir;
    o_load               = 1'b0;
    o_shift              = 8'h00;
    o_count              = CM_NONE;
    o_cmdvalid           = 1'b0;

    if (step) begin
      case (item.req_type)
        REQ_START: begin
          ovf_irq_on_next = 1'b1;
          phase_next      = PH_ADDR;
          o_count         = CM_START;
        end
        REQ_OVF: begin
          if (ovf_irq_on) begin
            unique case (phase) inside
              PH_ADDR: begin
                if ((item.shift_in & 8'hFE) == own_address) begin
                  o_load       = 1'b1;
                  sda_dir_next = 1'b1;
                  o_count      = CM_ONE;
                  if (item.shift_in[0]) begin
                    read_index_next      = '0;
                    phase_next           = PH_READ;
                    phase_after_ack_next = PH_IDLE;
                    count_after_ack_next = CM_NONE;
                  end else begin
                    phase_next           = PH_ACKSEND;
                    phase_after_ack_next = PH_WRITE;
                    count_after_ack_next = CM_EIGHT;
                  end
                end else begin
                  phase_next      = PH_IDLE;
                  ovf_irq_on_next = 1'b0;
                  o_count         = CM_START;
                  sda_dir_next    = 1'b0;
                end
              end
              PH_WRITE: begin
                command_reg_next     = item.shift_in;
                o_cmdvalid           = 1'b1;
                o_load               = 1'b1;
                sda_dir_next         = 1'b1;
                o_count              = CM_ONE;
                phase_next           = PH_ACKSEND;
                phase_after_ack_next = PH_IDLE;
                count_after_ack_next = CM_START;
              end
              PH_ACKSEND: begin
                sda_dir_next = 1'b0;
                o_count      = count_after_ack;
                phase_next   = phase_after_ack;
              end
              PH_PREPACK: begin
                latch_level_next = 1'b0;
                sda_dir_next     = 1'b0;
                phase_next       = PH_AWAITACK;
                o_count          = CM_ONE;
              end
              PH_READ, PH_AWAITACK: begin
                if (phase == PH_AWAITACK && item.shift_in[0]) begin
                  phase_next      = PH_IDLE;
                  ovf_irq_on_next = 1'b0;
                  o_count         = CM_START;
                  sda_dir_next    = 1'b0;
                end else begin
                  sda_dir_next     = 1'b1;
                  latch_level_next = 1'b1;
                  if (rd_hit) begin
                    read_index_next = read_index + RI_W'(1);
                  end
                  o_load     = 1'b1;
                  o_shift    = rd_byte;
                  o_count    = CM_EIGHT;
                  phase_next = PH_PREPACK;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end

    res.phase_code    = phase_code_f(phase_next);
    res.load_shift    = o_load;
    res.shift_out     = o_shift;
    res.sda_drive     = sda_dir_next;
    res.sda_latch     = latch_level_next;
    res.count_mode    = o_count;
    res.ovf_enable    = ovf_irq_on_next;
    res.command_byte  = command_reg_next;
    res.command_valid = o_cmdvalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      phase_after_ack <= PH_IDLE;
      count_after_ack <= CM_NONE;
      read_index      <= '0;
      command_reg     <= '0;
      ovf_irq_on      <= 1'b0;
      latch_level     <= 1'b0;
      sda_dir         <= 1'b0;
    end else begin
      phase           <= phase_next;
      phase_after_ack <= phase_after_ack_next;
      count_after_ack <= count_after_ack_next;
      read_index      <= read_index_next;
      command_reg     <= command_reg_next;
      ovf_irq_on      <= ovf_irq_on_next;
      latch_level     <= latch_level_next;
      sda_dir         <= sda_dir_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/i2cts_checker.sv -----
// ----------------------------------------------------------------------------
// i2cts_checker
// Port-level checks for the I2C target byte sequencer, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cts_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);
  import i2cts_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // nothing pending right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // reload value is zero unless a reload happens
  a_shift: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[3] |-> m_tdata[11:4] == 8'h00)
    else $error("shift value without reload");

  // a captured command is always acknowledged
  a_cmd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[25] |->
      m_tdata[2:0] == PC_ACKSEND && m_tdata[3] && m_tdata[12] &&
      m_tdata[15:14] == CM_ONE)
    else $error("command capture without ack");

  a_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] != 3'd7 && m_tdata[31:26] == 6'd0)
    else $error("bad phase code or pad bits");

endmodule

bind i2c_target_byte_sequencer_core i2cts_checker u_i2cts_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
